>>> src/ber_frame_delineator_macros.svh
// Assertion macros shared by the BER frame delineator RTL.
`ifndef BER_FRAME_DELINEATOR_MACROS_SVH
`define BER_FRAME_DELINEATOR_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define BER_FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define BER_FD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/ber_fd_pkg.sv
// Types and constants for the BER frame delineator.
package ber_fd_pkg;

  localparam logic [7:0]  TagResetValue = 8'h30;
  localparam logic [7:0]  LongForm      = 8'h80;
  localparam logic [6:0]  LenMask       = 7'h7f;
  localparam int unsigned SizeW         = 32;
  localparam int unsigned OctW          = 7;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_LEN     = 3'd1,
    PH_LENOCT  = 3'd2,
    PH_LENOVF  = 3'd3,
    PH_CONTENT = 3'd4,
    PH_SKIP    = 3'd5,
    PH_DRAIN   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_MORE     = 2'd1,
    ST_BADTAG   = 2'd2
  } status_e;

  typedef struct packed {
    phase_e             phase;
    logic [OctW-1:0]    oct_left;
    logic [SizeW-1:0]   content_len;
    logic [SizeW-1:0]   bytes_seen;
  } fd_state_t;

  typedef struct packed {
    status_e            status;
    logic [SizeW-1:0]   frame_size;
  } fd_result_t;

  localparam fd_state_t StateIdle = '{
    phase:       PH_TAG,
    oct_left:    '0,
    content_len: '0,
    bytes_seen:  '0
  };

endpackage

>>> src/ber_fd_ifs.sv
// Handshake channel interfaces of the BER frame delineator.
interface ber_fd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ber_fd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] frame_size;

  modport source (output valid, output status, output frame_size, input ready);
  modport sink   (input valid, input status, input frame_size, output ready);
endinterface

interface ber_fd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_tag;

  modport source (output valid, output expected_tag, input ready);
  modport sink   (input valid, input expected_tag, output ready);
endinterface

>>> src/ber_fd_step.sv
// Per-byte frame parser: next parser state and result for one item.
module ber_fd_step import ber_fd_pkg::*; (
  input  fd_state_t  state_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic [7:0] expected_tag_i,
  output fd_state_t  state_o,
  output logic       res_valid_o,
  output fd_result_t res_o
);

  logic             long_form;
  logic [OctW-1:0]  n_eff;
  logic [OctW-1:0]  oct_dec;
  logic             in_ovf;
  logic             going_ovf;
  logic [SizeW-1:0] cl_nx;
  logic [SizeW-1:0] cl_dec;
  logic [SizeW-1:0] bs_inc;
  logic             oversized;
  logic             tag_ok;
  phase_e           oct_phase_nx;

  assign long_form = (data_byte_i & LongForm) != 8'h00;
  // long form with a count of zero still reads one length octet
  assign n_eff     = ((data_byte_i[6:0] & LenMask) == '0) ? OctW'(1)
                                                           : (data_byte_i[6:0] & LenMask);
  assign oct_dec   = state_i.oct_left - OctW'(1);
  assign in_ovf    = (state_i.phase == PH_LENOVF);
  assign going_ovf = in_ovf || (state_i.content_len[31:24] != 8'h00);
  assign cl_nx     = in_ovf ? state_i.content_len : {state_i.content_len[23:0], data_byte_i};
  assign cl_dec    = state_i.content_len - SizeW'(1);
  assign bs_inc    = state_i.bytes_seen + SizeW'(1);
  assign oversized = going_ovf || cl_nx[SizeW-1];
  assign tag_ok    = (data_byte_i == expected_tag_i);
  assign oct_phase_nx = going_ovf ? PH_LENOVF : PH_LENOCT;

  // next state
  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      PH_LEN: begin
        if (long_form) begin
          if (last_byte_i) begin
            state_o = StateIdle;
          end else begin
            state_o.phase       = PH_LENOCT;
            state_o.oct_left    = n_eff;
            state_o.content_len = '0;
            state_o.bytes_seen  = SizeW'(2);
          end
        end else if ((data_byte_i == 8'h00) || last_byte_i) begin
          state_o = StateIdle;
        end else begin
          state_o.phase       = PH_CONTENT;
          state_o.content_len = {24'd0, data_byte_i};
          state_o.bytes_seen  = SizeW'(2);
        end
      end
      PH_LENOCT, PH_LENOVF: begin
        if (last_byte_i) begin
          state_o = StateIdle;
        end else if (oct_dec != '0) begin
          state_o.phase       = oct_phase_nx;
          state_o.oct_left    = oct_dec;
          state_o.content_len = cl_nx;
          state_o.bytes_seen  = bs_inc;
        end else if (oversized) begin
          state_o.phase       = PH_DRAIN;
          state_o.oct_left    = oct_dec;
          state_o.content_len = cl_nx;
          state_o.bytes_seen  = bs_inc;
        end else if (cl_nx == '0) begin
          state_o = StateIdle;
        end else begin
          state_o.phase       = PH_CONTENT;
          state_o.oct_left    = oct_dec;
          state_o.content_len = cl_nx;
          state_o.bytes_seen  = bs_inc;
        end
      end
      PH_CONTENT: begin
        if ((cl_dec == '0) || last_byte_i) begin
          state_o = StateIdle;
        end else begin
          state_o.content_len = cl_dec;
          state_o.bytes_seen  = bs_inc;
        end
      end
      PH_SKIP, PH_DRAIN: begin
        if (last_byte_i) begin
          state_o = StateIdle;
        end
      end
      default: begin
        state_o = StateIdle;
        if (!tag_ok) begin
          if (!last_byte_i) begin
            state_o.phase = PH_SKIP;
          end
        end else if (!last_byte_i) begin
          state_o.phase      = PH_LEN;
          state_o.bytes_seen = SizeW'(1);
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid_o      = 1'b0;
    res_o.status     = ST_MORE;
    res_o.frame_size = '0;
    case (state_i.phase)
      PH_LEN: begin
        if (!long_form && (data_byte_i == 8'h00)) begin
          res_valid_o      = 1'b1;
          res_o.status     = ST_COMPLETE;
          res_o.frame_size = SizeW'(2);
        end else begin
          res_valid_o = last_byte_i;
        end
      end
      PH_LENOCT, PH_LENOVF: begin
        if ((oct_dec == '0) && !oversized && (cl_nx == '0)) begin
          res_valid_o      = 1'b1;
          res_o.status     = ST_COMPLETE;
          res_o.frame_size = bs_inc;
        end else begin
          res_valid_o = last_byte_i;
        end
      end
      PH_CONTENT: begin
        if (cl_dec == '0) begin
          res_valid_o      = 1'b1;
          res_o.status     = ST_COMPLETE;
          res_o.frame_size = bs_inc;
        end else begin
          res_valid_o = last_byte_i;
        end
      end
      PH_SKIP: begin
        res_valid_o = 1'b0;
      end
      PH_DRAIN: begin
        res_valid_o = last_byte_i;
      end
      default: begin
        if (!tag_ok) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_BADTAG;
        end else begin
          res_valid_o = last_byte_i;
        end
      end
    endcase
  end

endmodule

>>> src/ber_frame_delineator.sv
// BER frame delineator: finds the end of each tag-length-content frame in a byte stream.
//
// in_ch_i   : one byte per item with a flag marking the last byte now in the buffer.
// out_ch_o  : at most one result per byte: status complete with the frame size
//             (header plus content bytes), more bytes needed, or tag mismatch.
//             After any result the parser starts on a new frame; after a tag
//             mismatch the bytes up to the next last byte are dropped silently.
// cfg_ch_i  : writes the expected tag; always ready; write only while idle.
// Throughput: one byte per cycle while the skid register is empty; the parser update is combinational.
// Results   : the result for a taken byte is registered in the output register,
//             or in the skid register while the receiver stalls the output.
// The result side has an output register and a one-entry skid register;
// input ready drops only while the skid register is full, so a stalled
// receiver holds the input back after at most one further result.
// Reset: parser waits for a tag byte, expected tag is 0x30, no result pending.
module ber_frame_delineator import ber_fd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ber_fd_in_if.sink   in_ch_i,
  ber_fd_out_if.source out_ch_o,
  ber_fd_cfg_if.sink  cfg_ch_i
);

`include "ber_frame_delineator_macros.svh"

  logic [7:0] tag_q;
  fd_state_t  state_q, state_d;
  logic       in_fire;
  logic       res_valid;
  fd_result_t res;
  logic       out_valid_q;
  fd_result_t out_q;
  logic       skid_valid_q;
  fd_result_t skid_q;
  logic       out_fire;
  logic       out_stall;
  logic       content_done;
  logic       out_other;

  assign cfg_ch_i.ready = 1'b1;
  assign in_ch_i.ready  = !skid_valid_q;
  assign in_fire        = in_ch_i.valid && !skid_valid_q;
  assign out_fire       = out_valid_q && out_ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TagResetValue;
    end else if (cfg_ch_i.valid) begin
      tag_q <= cfg_ch_i.expected_tag;
    end
  end

  ber_fd_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_ch_i.data_byte),
    .last_byte_i   (in_ch_i.last_byte),
    .expected_tag_i(tag_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_ch_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_ch_o.ready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.status     = out_q.status;
  assign out_ch_o.frame_size = out_q.frame_size;

  assign out_stall    = out_valid_q && !out_ch_o.ready;
  assign content_done = (state_q.phase == PH_CONTENT) && (state_q.content_len == '0);
  assign out_other    = out_valid_q && (out_q.status != ST_COMPLETE);

  `BER_FD_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `BER_FD_ASSERT(a_skid_on_stall, $rose(skid_valid_q) |-> $past(out_stall), "skid filled on no stall")
  `BER_FD_NEVER(a_content_nonzero, content_done, "content phase with nothing left")
  `BER_FD_ASSERT(a_size_only_complete, out_other |-> (out_q.frame_size == '0), "size on other")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the BER frame delineator: byte stream in, frame status out.
`timescale 1ns / 100ps

import ber_fd_pkg::*;

// Tracks the frame parser state and holds the results still owed by the block.
class frame_scoreboard;
  logic [7:0]  expected_tag;
  phase_e      phase;
  logic [6:0]  oct_left;
  logic [31:0] content_len;
  logic [31:0] bytes_seen;
  fd_result_t  awaited[$];
  int unsigned mismatches;

  function new();
    expected_tag = TagResetValue;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    phase = PH_TAG;
    oct_left = '0;
    content_len = '0;
    bytes_seen = '0;
  endfunction

  function void post(status_e st, logic [31:0] size);
    fd_result_t r;
    r.status = st;
    r.frame_size = size;
    awaited.push_back(r);
    restart();
  endfunction

  function void header_done(logic last);
    if (content_len == 0) begin
      post(ST_COMPLETE, bytes_seen);
    end else begin
      phase = PH_CONTENT;
      if (last) post(ST_MORE, '0);
    end
  endfunction

  // Advance the parser by one accepted item.
  function void note_byte(logic [7:0] b, logic last);
    case (phase)
      PH_LEN: begin
        bytes_seen = 32'd2;
        if (b[7]) begin
          // long form: a count of zero still reads one octet
          oct_left = (b[6:0] == '0) ? 7'd1 : b[6:0];
          content_len = '0;
          phase = PH_LENOCT;
          if (last) post(ST_MORE, '0);
        end else begin
          content_len = {24'd0, b};
          header_done(last);
        end
      end
      PH_LENOCT, PH_LENOVF: begin
        bytes_seen++;
        if (phase == PH_LENOCT) begin
          if (content_len[31:24] != '0) phase = PH_LENOVF;
          content_len = {content_len[23:0], b};
        end
        oct_left = oct_left - 7'd1;
        if (oct_left != '0) begin
          if (last) post(ST_MORE, '0);
        end else if (phase == PH_LENOVF || content_len[31]) begin
          if (last) post(ST_MORE, '0);
          else phase = PH_DRAIN;
        end else begin
          header_done(last);
        end
      end
      PH_CONTENT: begin
        bytes_seen++;
        content_len--;
        if (content_len == 0) post(ST_COMPLETE, bytes_seen);
        else if (last) post(ST_MORE, '0);
      end
      PH_SKIP: begin
        if (last) restart();
      end
      PH_DRAIN: begin
        if (last) post(ST_MORE, '0);
      end
      default: begin
        restart();
        bytes_seen = 32'd1;
        if (b != expected_tag) begin
          post(ST_BADTAG, '0);
          if (!last) phase = PH_SKIP;
        end else begin
          phase = PH_LEN;
          if (last) post(ST_MORE, '0);
        end
      end
    endcase
  endfunction

  function void check_result(logic [1:0] st, logic [31:0] size);
    fd_result_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d size %0d", st, size);
      return;
    end
    want = awaited.pop_front();
    if (st !== want.status || size !== want.frame_size) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected status %0d size %0d, got status %0d size %0d",
                 want.status, want.frame_size, st, size);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  frame_bytes[$];
  frame_scoreboard frame_sb;

  ber_fd_in_if  in_ch();
  ber_fd_out_if out_ch();
  ber_fd_cfg_if cfg_ch();

  ber_frame_delineator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls with a probability of about 17 percent unless calm
  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 17);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      frame_sb.check_result(out_ch.status, out_ch.frame_size);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    frame_sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic end_last);
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], end_last && (i == frame_bytes.size() - 1));
  endtask

  task automatic write_tag(input logic [7:0] tag);
    in_ch.valid <= 1'b0;
    while (frame_sb.awaited.size() != 0) @(posedge clk_i);
    // a byte that owes no result may still be in the parser
    repeat (4) @(posedge clk_i);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.expected_tag <= tag;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    frame_sb.expected_tag = tag;
  endtask

  task automatic random_frame();
    int unsigned kind, len, form, octs, cut;
    logic [7:0]  tag, b;
    tag = frame_sb.expected_tag;
    kind = $urandom_range(99);
    frame_bytes.delete();
    if (kind < 10) begin
      // plain noise
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame(1'($urandom_range(1)));
      return;
    end
    if (kind < 18) begin
      do b = 8'($urandom_range(255)); while (b == tag);
      frame_bytes.push_back(b);
      repeat ($urandom_range(0, 5)) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame(1'b1);
      return;
    end
    frame_bytes.push_back(tag);
    if (kind < 25) begin
      // length above 2^31-1, then drained up to the last byte
      case ($urandom_range(2))
        0: begin
          frame_bytes.push_back(LongForm | 8'd4);
          frame_bytes.push_back(8'h80 | 8'($urandom_range(127)));
          repeat (3) frame_bytes.push_back(8'($urandom_range(255)));
        end
        1: begin
          octs = $urandom_range(5, 8);
          frame_bytes.push_back(LongForm | 8'(octs));
          frame_bytes.push_back(8'($urandom_range(1, 255)));
          repeat (octs - 1) frame_bytes.push_back(8'($urandom_range(255)));
        end
        default: begin
          octs = $urandom_range(9, 40);
          frame_bytes.push_back(LongForm | 8'(octs));
          repeat (octs) frame_bytes.push_back(8'($urandom_range(255)));
        end
      endcase
      repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame(1'b1);
      return;
    end
    len = ($urandom_range(99) < 3) ? $urandom_range(128, 300) : $urandom_range(0, 12);
    form = $urandom_range(9);
    if (len <= 127 && form < 5) begin
      frame_bytes.push_back(8'(len));
    end else begin
      octs = (form < 7) ? 1 : $urandom_range(2, 4);
      if (len > 255 && octs < 2) octs = 2;
      frame_bytes.push_back(LongForm | 8'((octs == 1 && form == 5) ? 0 : octs));
      for (int i = octs - 1; i >= 0; i--) frame_bytes.push_back(8'(len >> (8 * i)));
    end
    repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 20) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      send_frame(1'b1);
    end else begin
      send_frame(1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [7:0]  phase_tags [5];
    int unsigned phase_start;
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.last_byte     <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.expected_tag <= '0;
    frame_sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero content, completes as the header ends
    send_byte(TagResetValue, 1'b0); send_byte(8'h00, 1'b0);
    // completes on a last byte
    send_byte(TagResetValue, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'hAA, 1'b1);
    // long form, one octet
    send_byte(TagResetValue, 1'b0); send_byte(8'h81, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b0);
    // long form with a zero count still reads one octet
    send_byte(TagResetValue, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
    // buffer ends early
    send_byte(TagResetValue, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h11, 1'b1);
    // tag mismatch, rest of buffer skipped
    send_byte(8'h31, 1'b0); send_byte(8'h55, 1'b0); send_byte(8'h66, 1'b1);
    // mismatching tag that is itself the last byte
    send_byte(8'h00, 1'b1);
    // oversized length drained up to the last byte
    send_byte(TagResetValue, 1'b0); send_byte(8'h84, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b1);
    // lone tag at the end of the buffer
    send_byte(TagResetValue, 1'b1);

    phase_tags[0] = 8'h00;
    phase_tags[1] = 8'hFF;
    phase_tags[2] = 8'($urandom_range(255));
    phase_tags[3] = 8'($urandom_range(255));
    phase_tags[4] = TagResetValue;
    foreach (phase_tags[p]) begin
      write_tag(phase_tags[p]);
      calm = (p == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 130) random_frame();
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (frame_sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (frame_sb.mismatches == 0 && frame_sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/ber_fd_pkg.sv
src/ber_fd_ifs.sv
src/ber_fd_step.sv
src/ber_frame_delineator.sv
verif/testbench.sv
